// ===== rtl/mi3_pkg.sv =====
// Shared types, constants and helper functions for the 3x3 matrix inverse.
// Used by the top level, the MAC and the divider; depends on nothing.
package mi3_pkg;

  localparam int ELEM_W = 32;
  localparam int THR_W  = 31;
  localparam int IDX_W  = 4;
  localparam int DEPTH  = 9;
  localparam int ADJ_W  = 64;
  localparam int OPND_W = 33;
  localparam int PROD_W = 66;
  localparam int DET_W  = 98;
  localparam int NOPS   = 24;
  localparam int OP_W   = 5;
  localparam logic [THR_W-1:0] THR_RESET = 31'd17;

  typedef enum logic [1:0] {BSRC_MAT, BSRC_ADJ_HI, BSRC_ADJ_LO} bsrc_t;
  typedef enum logic [1:0] {ACC_LOAD, ACC_ADD, ACC_SUB} acc_mode_t;

  typedef struct packed {
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    bsrc_t            bsrc;
    acc_mode_t        mode;
    logic             shift;
    logic             wb;
  } mac_op_t;

  typedef struct packed {
    logic      mul_en;
    logic      acc_en;
    acc_mode_t mode;
    logic      shift;
  } mac_ctrl_t;

  typedef enum logic [2:0] {
    ST_LOAD, ST_MAC, ST_MAG, ST_CHECK, ST_DIV_READ, ST_DIV_START, ST_DIV_WAIT, ST_OUT
  } state_t;

  typedef enum logic [1:0] {DV_IDLE, DV_RUN, DV_FIN} div_state_t;

  function automatic mac_op_t mk_op(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b, bsrc_t bsrc,
                                    acc_mode_t mode, logic shift, logic wb);
    mac_op_t o;
    o.a = a;
    o.b = b;
    o.bsrc = bsrc;
    o.mode = mode;
    o.shift = shift;
    o.wb = wb;
    return o;
  endfunction

  // Cofactors first (two products each, written back after the second),
  // then det = m0*adj0 + m1*adj3 + m2*adj6 in 32-bit halves of each cofactor.
  function automatic mac_op_t op_rom(logic [OP_W-1:0] idx);
    mac_op_t o;
    case (idx)
      5'd0:  o = mk_op(4'd4, 4'd8, BSRC_MAT, ACC_LOAD, 1'b0, 1'b0);
      5'd1:  o = mk_op(4'd5, 4'd7, BSRC_MAT, ACC_SUB, 1'b0, 1'b1);
      5'd2:  o = mk_op(4'd2, 4'd7, BSRC_MAT, ACC_LOAD, 1'b0, 1'b0);
      5'd3:  o = mk_op(4'd1, 4'd8, BSRC_MAT, ACC_SUB, 1'b0, 1'b1);
      5'd4:  o = mk_op(4'd1, 4'd5, BSRC_MAT, ACC_LOAD, 1'b0, 1'b0);
      5'd5:  o = mk_op(4'd2, 4'd4, BSRC_MAT, ACC_SUB, 1'b0, 1'b1);
      5'd6:  o = mk_op(4'd5, 4'd6, BSRC_MAT, ACC_LOAD, 1'b0, 1'b0);
      5'd7:  o = mk_op(4'd3, 4'd8, BSRC_MAT, ACC_SUB, 1'b0, 1'b1);
      5'd8:  o = mk_op(4'd0, 4'd8, BSRC_MAT, ACC_LOAD, 1'b0, 1'b0);
      5'd9:  o = mk_op(4'd2, 4'd6, BSRC_MAT, ACC_SUB, 1'b0, 1'b1);
      5'd10: o = mk_op(4'd2, 4'd3, BSRC_MAT, ACC_LOAD, 1'b0, 1'b0);
      5'd11: o = mk_op(4'd0, 4'd5, BSRC_MAT, ACC_SUB, 1'b0, 1'b1);
      5'd12: o = mk_op(4'd3, 4'd7, BSRC_MAT, ACC_LOAD, 1'b0, 1'b0);
      5'd13: o = mk_op(4'd4, 4'd6, BSRC_MAT, ACC_SUB, 1'b0, 1'b1);
      5'd14: o = mk_op(4'd1, 4'd6, BSRC_MAT, ACC_LOAD, 1'b0, 1'b0);
      5'd15: o = mk_op(4'd0, 4'd7, BSRC_MAT, ACC_SUB, 1'b0, 1'b1);
      5'd16: o = mk_op(4'd0, 4'd4, BSRC_MAT, ACC_LOAD, 1'b0, 1'b0);
      5'd17: o = mk_op(4'd1, 4'd3, BSRC_MAT, ACC_SUB, 1'b0, 1'b1);
      5'd18: o = mk_op(4'd0, 4'd0, BSRC_ADJ_HI, ACC_LOAD, 1'b1, 1'b0);
      5'd19: o = mk_op(4'd0, 4'd0, BSRC_ADJ_LO, ACC_ADD, 1'b0, 1'b0);
      5'd20: o = mk_op(4'd1, 4'd3, BSRC_ADJ_HI, ACC_ADD, 1'b1, 1'b0);
      5'd21: o = mk_op(4'd1, 4'd3, BSRC_ADJ_LO, ACC_ADD, 1'b0, 1'b0);
      5'd22: o = mk_op(4'd2, 4'd6, BSRC_ADJ_HI, ACC_ADD, 1'b1, 1'b0);
      5'd23: o = mk_op(4'd2, 4'd6, BSRC_ADJ_LO, ACC_ADD, 1'b0, 1'b0);
      default: o = mk_op(4'd0, 4'd0, BSRC_MAT, ACC_LOAD, 1'b0, 1'b0);
    endcase
    return o;
  endfunction

  // Saturate a magnitude with sign to a signed 32-bit word.
  function automatic logic [ELEM_W-1:0] sat32(logic [DET_W-1:0] mag, logic neg);
    logic [ELEM_W-1:0] r;
    if (!neg) begin
      if (mag > DET_W'(32'h7FFF_FFFF)) r = 32'h7FFF_FFFF;
      else r = mag[ELEM_W-1:0];
    end else begin
      if (mag >= DET_W'(32'h8000_0000)) r = 32'h8000_0000;
      else r = -mag[ELEM_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/mi3_ifs.sv =====
// Valid/ready channel interfaces for the matrix inverse: element in,
// result out and threshold write. Depends on nothing.
interface mi3_elem_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] element;
  modport source(output valid, output element, input ready);
  modport sink(input valid, input element, output ready);
endinterface

interface mi3_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] inverse_element;
  logic signed [31:0] determinant;
  logic               singular;
  logic               last;
  modport source(output valid, output inverse_element, output determinant,
                 output singular, output last, input ready);
  modport sink(input valid, input inverse_element, input determinant,
               input singular, input last, output ready);
endinterface

interface mi3_cfg_if;
  logic        valid;
  logic        ready;
  logic [30:0] det_threshold;
  modport source(output valid, output det_threshold, input ready);
  modport sink(input valid, input det_threshold, output ready);
endinterface

// ===== rtl/matrix_inverse_3x3.sv =====
// 3x3 matrix inverse by adjugate over determinant, signed Q(32-F).F words.
// Nine elements are taken one per cycle in row-major order. The block then
// drops ready and runs 24 multiply-accumulate ops through one shared 33x33
// multiplier, forming the nine exact cofactors and the exact determinant,
// then goes through a magnitude state and a check state for rounding and
// the threshold test. A singular matrix gives one word. Otherwise each of
// the nine inverse entries goes through a one-bit-per-cycle restoring
// divider, and the next entry is not started until the result side has
// taken the previous word. The threshold may be written at any time when idle.
module matrix_inverse_3x3 #(
  parameter int FRAC_BITS = 24
) (
  input  logic              clk,
  input  logic              rst,
  mi3_elem_if.sink          elem,
  mi3_result_if.source      result,
  mi3_cfg_if.sink           cfg
);

  localparam int RND_SH = 2 * FRAC_BITS;

  mi3_pkg::state_t state, state_next;

  logic [mi3_pkg::IDX_W-1:0]  load_count;
  logic [mi3_pkg::OP_W-1:0]   op_idx;
  logic [1:0]                 phase;
  logic [mi3_pkg::IDX_W-1:0]  div_k;
  logic [mi3_pkg::THR_W-1:0]  thr;

  logic [mi3_pkg::ELEM_W-1:0] matrix_store [mi3_pkg::DEPTH];
  logic [mi3_pkg::ADJ_W-1:0]  adj_mem [mi3_pkg::DEPTH];
  logic [mi3_pkg::ELEM_W-1:0] mat_rd;
  logic [mi3_pkg::ADJ_W-1:0]  adj_rd;
  logic [mi3_pkg::IDX_W-1:0]  mat_raddr, adj_raddr;
  logic                       adj_wr_en;
  logic [mi3_pkg::IDX_W-1:0]  adj_wr_idx;

  mi3_pkg::mac_op_t   op;
  mi3_pkg::mac_ctrl_t mac_ctrl;
  logic                                opa_load;
  logic signed [mi3_pkg::OPND_W-1:0]   opa, opb;
  logic signed [mi3_pkg::DET_W-1:0]    acc;

  logic [mi3_pkg::DET_W-1:0]  dmag;
  logic                       dneg;
  logic [mi3_pkg::ELEM_W-1:0] detbits;
  logic [mi3_pkg::DET_W-1:0]  dsum, thr_sh;
  logic [mi3_pkg::ELEM_W-1:0] det_sat;
  logic                       is_sing;

  logic                       div_start, div_done;
  logic [mi3_pkg::ELEM_W-1:0] div_q;

  logic                       out_load, out_valid;
  logic [mi3_pkg::ELEM_W-1:0] out_inv, out_inv_next, out_det, out_det_next;
  logic                       out_sing, out_sing_next, out_last, out_last_next;

  logic elem_acc, result_acc;

  assign elem_acc   = elem.valid && elem.ready;
  assign result_acc = result.valid && result.ready;
  assign op         = mi3_pkg::op_rom(op_idx);

  assign elem.ready             = (state == mi3_pkg::ST_LOAD);
  assign cfg.ready              = 1'b1;
  assign result.valid           = out_valid;
  assign result.inverse_element = out_inv;
  assign result.determinant     = out_det;
  assign result.singular        = out_sing;
  assign result.last            = out_last;

  always_comb begin
    dsum    = dmag + (mi3_pkg::DET_W'(1) << (RND_SH - 1));
    det_sat = mi3_pkg::sat32(dsum >> RND_SH, dneg);
    thr_sh  = mi3_pkg::DET_W'(thr) << RND_SH;
    is_sing = (dmag == '0) || (dmag < thr_sh);
  end

  always_comb begin
    case (op.bsrc)
      mi3_pkg::BSRC_MAT:    opb = {mat_rd[31], mat_rd};
      mi3_pkg::BSRC_ADJ_HI: opb = {adj_rd[63], adj_rd[63:32]};
      mi3_pkg::BSRC_ADJ_LO: opb = {1'b0, adj_rd[31:0]};
      default:              opb = '0;
    endcase
  end

  // Sequencer: next state and datapath strobes.
  always_comb begin
    state_next    = state;
    mat_raddr     = op.a;
    adj_raddr     = op.b;
    opa_load      = 1'b0;
    mac_ctrl      = '0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    out_inv_next  = div_q;
    out_det_next  = detbits;
    out_sing_next = 1'b0;
    out_last_next = (div_k == mi3_pkg::IDX_W'(mi3_pkg::DEPTH - 1));
    case (state)
      mi3_pkg::ST_LOAD: begin
        if (elem_acc && load_count == mi3_pkg::IDX_W'(mi3_pkg::DEPTH - 1))
          state_next = mi3_pkg::ST_MAC;
      end
      mi3_pkg::ST_MAC: begin
        case (phase)
          2'd0: mat_raddr = op.a;
          2'd1: begin
            opa_load  = 1'b1;
            mat_raddr = op.b;
          end
          2'd2: mac_ctrl.mul_en = 1'b1;
          default: begin
            mac_ctrl.acc_en = 1'b1;
            mac_ctrl.mode   = op.mode;
            mac_ctrl.shift  = op.shift;
            if (op_idx == mi3_pkg::OP_W'(mi3_pkg::NOPS - 1)) state_next = mi3_pkg::ST_MAG;
          end
        endcase
      end
      mi3_pkg::ST_MAG: state_next = mi3_pkg::ST_CHECK;
      mi3_pkg::ST_CHECK: begin
        if (is_sing) begin
          out_load      = 1'b1;
          out_inv_next  = '0;
          out_det_next  = det_sat;
          out_sing_next = 1'b1;
          out_last_next = 1'b1;
          state_next    = mi3_pkg::ST_OUT;
        end else begin
          state_next = mi3_pkg::ST_DIV_READ;
        end
      end
      mi3_pkg::ST_DIV_READ: begin
        adj_raddr  = div_k;
        state_next = mi3_pkg::ST_DIV_START;
      end
      mi3_pkg::ST_DIV_START: begin
        div_start  = 1'b1;
        state_next = mi3_pkg::ST_DIV_WAIT;
      end
      mi3_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          out_load   = 1'b1;
          state_next = mi3_pkg::ST_OUT;
        end
      end
      mi3_pkg::ST_OUT: begin
        if (result_acc) state_next = out_last ? mi3_pkg::ST_LOAD : mi3_pkg::ST_DIV_READ;
      end
      default: state_next = mi3_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mi3_pkg::ST_LOAD;
      load_count <= '0;
      op_idx     <= '0;
      phase      <= '0;
      div_k      <= '0;
      thr        <= mi3_pkg::THR_RESET;
      adj_wr_en  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      adj_wr_en <= (state == mi3_pkg::ST_MAC) && (phase == 2'd3) && op.wb;
      if (cfg.valid) thr <= cfg.det_threshold;
      if (elem_acc)
        load_count <= (load_count >= mi3_pkg::IDX_W'(mi3_pkg::DEPTH - 1)) ? '0
                                                                          : load_count + 1'b1;
      if (state == mi3_pkg::ST_MAC) begin
        phase <= phase + 2'd1;
        if (phase == 2'd3)
          op_idx <= (op_idx == mi3_pkg::OP_W'(mi3_pkg::NOPS - 1)) ? '0 : op_idx + 1'b1;
      end
      if (state == mi3_pkg::ST_CHECK) div_k <= '0;
      else if (state == mi3_pkg::ST_OUT && result_acc && !out_last) div_k <= div_k + 1'b1;
      if (out_load) out_valid <= 1'b1;
      else if (result_acc) out_valid <= 1'b0;
    end
  end

  // Element and cofactor stores, registered reads.
  always_ff @(posedge clk) begin
    if (elem_acc) matrix_store[load_count] <= elem.element;
    if (adj_wr_en) adj_mem[adj_wr_idx] <= acc[mi3_pkg::ADJ_W-1:0];
    mat_rd <= matrix_store[mat_raddr];
    adj_rd <= adj_mem[adj_raddr];
  end

  always_ff @(posedge clk) begin
    adj_wr_idx <= op_idx[mi3_pkg::OP_W-1:1];
    if (opa_load) opa <= {mat_rd[31], mat_rd};
    if (state == mi3_pkg::ST_MAG) begin
      dneg <= acc[mi3_pkg::DET_W-1];
      dmag <= acc[mi3_pkg::DET_W-1] ? mi3_pkg::DET_W'(-acc) : mi3_pkg::DET_W'(acc);
    end
    if (state == mi3_pkg::ST_CHECK) detbits <= det_sat;
    if (out_load) begin
      out_inv  <= out_inv_next;
      out_det  <= out_det_next;
      out_sing <= out_sing_next;
      out_last <= out_last_next;
    end
  end

  mi3_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .opa  (opa),
    .opb  (opb),
    .acc  (acc)
  );

  mi3_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .adj   (adj_rd),
    .dmag  (dmag),
    .dneg  (dneg),
    .done  (div_done),
    .quot  (div_q)
  );

endmodule

// ===== rtl/mi3_mac.sv =====
// Shared 33x33 signed multiplier with a 98-bit accumulator.
// Depends on mi3_pkg for widths and the control struct.
module mi3_mac (
  input  logic                                clk,
  input  mi3_pkg::mac_ctrl_t                  ctrl,
  input  logic signed [mi3_pkg::OPND_W-1:0]   opa,
  input  logic signed [mi3_pkg::OPND_W-1:0]   opb,
  output logic signed [mi3_pkg::DET_W-1:0]    acc
);

  logic signed [mi3_pkg::PROD_W-1:0] prod;
  logic signed [mi3_pkg::DET_W-1:0]  ext;
  logic signed [mi3_pkg::DET_W-1:0]  term;
  logic signed [mi3_pkg::DET_W-1:0]  acc_next;

  always_comb begin
    ext  = {{(mi3_pkg::DET_W - mi3_pkg::PROD_W){prod[mi3_pkg::PROD_W-1]}}, prod};
    term = ctrl.shift ? (ext <<< 32) : ext;
    case (ctrl.mode)
      mi3_pkg::ACC_LOAD: acc_next = term;
      mi3_pkg::ACC_ADD:  acc_next = acc + term;
      mi3_pkg::ACC_SUB:  acc_next = acc - term;
      default:           acc_next = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) prod <= opa * opb;
    if (ctrl.acc_en) acc <= acc_next;
  end

endmodule

// ===== rtl/mi3_div.sv =====
// Restoring divider, one quotient bit a cycle: |cofactor| * 2^F / |det|,
// rounded half away from zero and saturated. Depends on mi3_pkg.
module mi3_div #(
  parameter int FRAC_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [mi3_pkg::ADJ_W-1:0]     adj,
  input  logic [mi3_pkg::DET_W-1:0]     dmag,
  input  logic                          dneg,
  output logic                          done,
  output logic [mi3_pkg::ELEM_W-1:0]    quot
);

  localparam int NUM_W = mi3_pkg::ADJ_W + FRAC_BITS;
  localparam int TOP_W = NUM_W - 32;
  localparam int R_W   = mi3_pkg::DET_W + 1;

  mi3_pkg::div_state_t st;
  logic [R_W-1:0]      r;
  logic [31:0]         nlow;
  logic [31:0]         q;
  logic [4:0]          cnt;
  logic                neg;
  logic                ovf;

  logic [mi3_pkg::ADJ_W-1:0] amag;
  logic [NUM_W-1:0]          num;
  logic [TOP_W-1:0]          top;
  logic [R_W-1:0]            rs;
  logic [R_W-1:0]            dext;
  logic                      up;
  logic [32:0]               qr;
  logic [mi3_pkg::ELEM_W-1:0] res;

  always_comb begin
    amag = adj[mi3_pkg::ADJ_W-1] ? (~adj + 1'b1) : adj;
    num  = {amag, {FRAC_BITS{1'b0}}};
    top  = num[NUM_W-1:32];
    dext = R_W'(dmag);
    rs   = {r[R_W-2:0], nlow[31]};
    up   = ({r[R_W-2:0], 1'b0} >= dext);
    qr   = {1'b0, q} + 33'(up);
    res  = ovf ? mi3_pkg::sat32({mi3_pkg::DET_W{1'b1}}, neg)
               : mi3_pkg::sat32(mi3_pkg::DET_W'(qr), neg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= mi3_pkg::DV_IDLE;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      case (st)
        mi3_pkg::DV_IDLE: begin
          if (start) begin
            cnt <= '0;
            st  <= (mi3_pkg::DET_W'(top) >= dmag) ? mi3_pkg::DV_FIN : mi3_pkg::DV_RUN;
          end
        end
        mi3_pkg::DV_RUN: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) st <= mi3_pkg::DV_FIN;
        end
        mi3_pkg::DV_FIN: begin
          done <= 1'b1;
          st   <= mi3_pkg::DV_IDLE;
        end
        default: st <= mi3_pkg::DV_IDLE;
      endcase
    end
  end

  // Datapath: partial remainder stays below the divisor.
  always_ff @(posedge clk) begin
    case (st)
      mi3_pkg::DV_IDLE: begin
        if (start) begin
          r    <= R_W'(top);
          nlow <= num[31:0];
          q    <= '0;
          neg  <= adj[mi3_pkg::ADJ_W-1] ^ dneg;
          ovf  <= (mi3_pkg::DET_W'(top) >= dmag);
        end
      end
      mi3_pkg::DV_RUN: begin
        nlow <= {nlow[30:0], 1'b0};
        if (rs >= dext) begin
          r <= rs - dext;
          q <= {q[30:0], 1'b1};
        end else begin
          r <= rs;
          q <= {q[30:0], 1'b0};
        end
      end
      mi3_pkg::DV_FIN: quot <= res;
      default: ;
    endcase
  end

endmodule

// ===== rtl/mi3_checker.sv =====
// Port-level checks for matrix_inverse_3x3, attached by bind.
// Depends only on the top level's channel signals.
module mi3_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] inverse_element,
  input logic [31:0] determinant,
  input logic        singular,
  input logic        last
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(inverse_element)
      && $stable(determinant) && $stable(singular) && $stable(last))
    else $error("result word changed while stalled");

  // No new element is taken while results are pending.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  // A singular word is the only word of its matrix and carries no inverse.
  a_singular: assert property (@(posedge clk) disable iff (rst)
    out_valid && singular |-> last && inverse_element == 32'd0)
    else $error("singular word without last or with nonzero inverse");

endmodule

bind matrix_inverse_3x3 mi3_checker u_mi3_checker (
  .clk             (clk),
  .rst             (rst),
  .in_ready        (elem.ready),
  .out_valid       (result.valid),
  .out_ready       (result.ready),
  .inverse_element (result.inverse_element),
  .determinant     (result.determinant),
  .singular        (result.singular),
  .last            (result.last)
);
